// File: rtl/core/slsm_pkg.sv
`default_nettype none

package slsm_pkg;

  // pin positions in the sampled pin vector
  localparam int unsigned NUM_PINS  = 6;
  localparam int unsigned PIN_COM   = 0;
  localparam int unsigned PIN_RED   = 1;
  localparam int unsigned PIN_GREEN = 2;
  localparam int unsigned PIN_YEL   = 3;
  localparam int unsigned PIN_CLOSE = 4;
  localparam int unsigned PIN_COUNT = 5;

  // queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = 1;
  localparam int unsigned QUEUE_CNT_W = 2;

  // configuration port geometry
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;

  localparam logic [15:0] PIECE_MAX = 16'hFFFF;

  typedef enum logic [1:0] {
    ST_NONE    = 2'd0,
    ST_READY   = 2'd1,
    ST_RUNNING = 2'd2,
    ST_ALERT   = 2'd3
  } state_e;

  typedef enum logic [1:0] {
    MODE_MACHINING = 2'd0,
    MODE_INJECTION = 2'd1,
    MODE_PRESS     = 2'd2,
    MODE_INJ_NOLMP = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    CFG_MODE     = 2'd0,
    CFG_RUN_HOLD = 2'd1,
    CFG_INTERVAL = 2'd2,
    CFG_LIMIT    = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    mode_e       mode;
    logic [15:0] run_hold;
    logic [23:0] interval;
    logic [15:0] limit;
  } cfg_t;

  // one debounced sample handed from front to back
  typedef struct packed {
    logic [NUM_PINS-1:0] levels;
    logic                piece_ev;
  } entry_t;

endpackage

`default_nettype wire

// File: rtl/core/stack_light_machine_state_monitor.sv
// Stack-light machine state monitor.
// Input channel (in_valid_i/in_ready_o): one transaction per sample tick carrying the six
// raw machine pins. Each pin is debounced by a shift register; the front debounces and
// detects piece events, a two-entry queue decouples it from the back, which classifies
// the machine as ready, running or alert and tracks segments, hold and piece counts.
// Output channel (out_valid_o/out_ready_i): zero or one segment report per sample, in
// sample order, when the state changes, the report interval expires or the piece count
// reaches its limit. The first segment after reset is not reported.
// Throughput: one sample per cycle while the output is taken. An accepted sample enters
// the queue at the accepting edge; the back pops it and loads the output register.
// When the receiver stalls the held report stays, the back stops, and the queue fills;
// in_ready_o falls only once both queue entries are occupied.
// Reset clears configuration to zero, the tick counter and the segment state; the first
// sample after reset loads the debouncers. The user must write configuration through
// cfg_we_i/cfg_idx_i/cfg_data_i only while no sample is in flight; this is not enforced.
`default_nettype none

module stack_light_machine_state_monitor #(
  parameter int unsigned DEBOUNCE_BITS = 8,
  parameter int unsigned TIME_BITS     = 32
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [slsm_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [slsm_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic                              pin_common_i,
  input  wire logic                              pin_red_i,
  input  wire logic                              pin_green_i,
  input  wire logic                              pin_yellow_i,
  input  wire logic                              pin_mold_close_i,
  input  wire logic                              pin_piece_count_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [1:0]                             segment_state_o,
  output logic [31:0]                            segment_begin_o,
  output logic [31:0]                            segment_end_o,
  output logic [31:0]                            segment_duration_o,
  output logic                                   run_hold_flag_o,
  output logic [15:0]                            segment_pieces_o,
  output logic [1:0]                             new_state_o
);

  slsm_pkg::cfg_t                    cfg_q;
  logic [slsm_pkg::NUM_PINS-1:0]     pins;
  logic                              q_full, q_push, q_pop, q_valid;
  slsm_pkg::entry_t                  q_in, q_out;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (slsm_pkg::cfg_idx_e'(cfg_idx_i))
        slsm_pkg::CFG_MODE:     cfg_q.mode     <= slsm_pkg::mode_e'(cfg_data_i[1:0]);
        slsm_pkg::CFG_RUN_HOLD: cfg_q.run_hold <= cfg_data_i[15:0];
        slsm_pkg::CFG_INTERVAL: cfg_q.interval <= cfg_data_i[23:0];
        slsm_pkg::CFG_LIMIT:    cfg_q.limit    <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // gather pins in package order
  always_comb begin
    pins = '0;
    pins[slsm_pkg::PIN_COM]   = pin_common_i;
    pins[slsm_pkg::PIN_RED]   = pin_red_i;
    pins[slsm_pkg::PIN_GREEN] = pin_green_i;
    pins[slsm_pkg::PIN_YEL]   = pin_yellow_i;
    pins[slsm_pkg::PIN_CLOSE] = pin_mold_close_i;
    pins[slsm_pkg::PIN_COUNT] = pin_piece_count_i;
  end

  slsm_front #(
    .DEBOUNCE_BITS(DEBOUNCE_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .pins_i     (pins),
    .q_full_i   (q_full),
    .push_o     (q_push),
    .entry_o    (q_in)
  );

  slsm_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_in),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_out)
  );

  slsm_back #(
    .TIME_BITS(TIME_BITS)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg_q),
    .q_valid_i          (q_valid),
    .q_data_i           (q_out),
    .q_pop_o            (q_pop),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .segment_state_o    (segment_state_o),
    .segment_begin_o    (segment_begin_o),
    .segment_end_o      (segment_end_o),
    .segment_duration_o (segment_duration_o),
    .run_hold_flag_o    (run_hold_flag_o),
    .segment_pieces_o   (segment_pieces_o),
    .new_state_o        (new_state_o)
  );

endmodule

`default_nettype wire

// File: rtl/core/slsm_front.sv
`default_nettype none

module slsm_front #(
  parameter int unsigned DEBOUNCE_BITS = 8
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire slsm_pkg::cfg_t                    cfg_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic [slsm_pkg::NUM_PINS-1:0]     pins_i,
  input  wire logic                              q_full_i,
  output logic                                   push_o,
  output slsm_pkg::entry_t                       entry_o
);

  localparam logic [DEBOUNCE_BITS-1:0] DbFall = {1'b1, {(DEBOUNCE_BITS-1){1'b0}}};
  localparam logic [DEBOUNCE_BITS-1:0] DbRise = {1'b0, {(DEBOUNCE_BITS-1){1'b1}}};

  logic [DEBOUNCE_BITS-1:0]          hist_q [slsm_pkg::NUM_PINS];
  logic [DEBOUNCE_BITS-1:0]          hist_d [slsm_pkg::NUM_PINS];
  logic [slsm_pkg::NUM_PINS-1:0]     lvl_q, lvl_d;
  logic [slsm_pkg::NUM_PINS-1:0]     fall;
  logic                              first_q;

  // accept whenever the queue has room
  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  // shift debouncers, first sample loads directly
  always_comb begin
    for (int i = 0; i < slsm_pkg::NUM_PINS; i++) begin
      fall[i] = 1'b0;
      lvl_d[i] = lvl_q[i];
      if (first_q) begin
        hist_d[i] = {DEBOUNCE_BITS{pins_i[i]}};
        lvl_d[i]  = pins_i[i];
      end else begin
        hist_d[i] = {hist_q[i][DEBOUNCE_BITS-2:0], pins_i[i]};
        if (hist_d[i] == DbFall) begin
          lvl_d[i] = 1'b0;
          fall[i]  = 1'b1;
        end else if (hist_d[i] == DbRise) begin
          lvl_d[i] = 1'b1;
        end
      end
    end
  end

  // piece event source depends on the machine mode
  always_comb begin
    entry_o.levels = lvl_d;
    if (cfg_i.mode == slsm_pkg::MODE_INJECTION) begin
      entry_o.piece_ev = fall[slsm_pkg::PIN_CLOSE];
    end else begin
      entry_o.piece_ev = fall[slsm_pkg::PIN_COUNT];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= 1'b1;
      lvl_q   <= '0;
    end else if (push_o) begin
      first_q <= 1'b0;
      lvl_q   <= lvl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_o) begin
      for (int i = 0; i < slsm_pkg::NUM_PINS; i++) begin
        hist_q[i] <= hist_d[i];
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/slsm_queue.sv
`default_nettype none

module slsm_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire slsm_pkg::entry_t push_data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  valid_o,
  output slsm_pkg::entry_t      pop_data_o
);

  slsm_pkg::entry_t                   mem_q [slsm_pkg::QUEUE_DEPTH];
  logic [slsm_pkg::QUEUE_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [slsm_pkg::QUEUE_CNT_W-1:0]   cnt_q;
  logic                               do_push, do_pop;

  assign full_o     = (cnt_q == slsm_pkg::QUEUE_CNT_W'(slsm_pkg::QUEUE_DEPTH));
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // fill count stays within depth
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= slsm_pkg::QUEUE_CNT_W'(slsm_pkg::QUEUE_DEPTH))
    else $error("queue fill count above depth");

  // pointers differ by the fill count
  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0 || cnt_q == slsm_pkg::QUEUE_CNT_W'(slsm_pkg::QUEUE_DEPTH))
      == (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers out of step with fill count");

endmodule

`default_nettype wire

// File: rtl/core/slsm_back.sv
`default_nettype none

module slsm_back #(
  parameter int unsigned TIME_BITS = 32
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire slsm_pkg::cfg_t   cfg_i,
  input  wire logic             q_valid_i,
  input  wire slsm_pkg::entry_t q_data_i,
  output logic                  q_pop_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [1:0]            segment_state_o,
  output logic [31:0]           segment_begin_o,
  output logic [31:0]           segment_end_o,
  output logic [31:0]           segment_duration_o,
  output logic                  run_hold_flag_o,
  output logic [15:0]           segment_pieces_o,
  output logic [1:0]            new_state_o
);

  // classifier and segment state
  slsm_pkg::state_e        cur_q, cls_s;
  logic                    hold_q, hold_d;
  logic                    arm_q, arm_d;
  logic [TIME_BITS-1:0]    hold_dl_q, hold_dl_d;
  logic [TIME_BITS-1:0]    rep_dl_q;
  logic [15:0]             piece_q, piece_nx;
  logic [TIME_BITS-1:0]    start_q;
  logic                    known_q;
  logic [TIME_BITS-1:0]    tick_q;
  logic                    out_valid_q;

  logic                    take, report;
  logic                    com, red, green, yellow, closed, cnt;
  logic                    hold_pass, rep_pass, limit_hit;
  logic [TIME_BITS-1:0]    hold_target, dur;

  function automatic logic passed(logic [TIME_BITS-1:0] now, logic [TIME_BITS-1:0] dl);
    logic [TIME_BITS-1:0] d;
    d = now - dl;
    return (d != '0) && !d[TIME_BITS-1];
  endfunction

  // process one queued sample whenever the output slot is free or draining
  assign take    = q_valid_i && (!out_valid_q || out_ready_i);
  assign q_pop_o = take;

  // lamp decoding from debounced levels
  assign com    = q_data_i.levels[slsm_pkg::PIN_COM];
  assign red    = q_data_i.levels[slsm_pkg::PIN_RED] != com;
  assign green  = q_data_i.levels[slsm_pkg::PIN_GREEN] != com;
  assign yellow = q_data_i.levels[slsm_pkg::PIN_YEL] != com;
  assign closed = !q_data_i.levels[slsm_pkg::PIN_CLOSE];
  assign cnt    = !q_data_i.levels[slsm_pkg::PIN_COUNT];

  assign hold_target = tick_q + TIME_BITS'(cfg_i.run_hold);
  assign hold_pass   = passed(tick_q, hold_dl_q);
  assign rep_pass    = passed(tick_q, rep_dl_q);
  assign dur         = tick_q - start_q;

  // saturating piece count
  assign piece_nx = (q_data_i.piece_ev && piece_q != slsm_pkg::PIECE_MAX) ?
                    piece_q + 16'd1 : piece_q;
  assign limit_hit = (cfg_i.limit != '0) && (piece_nx >= cfg_i.limit);

  // state classifier
  always_comb begin
    hold_d    = hold_q;
    arm_d     = arm_q;
    hold_dl_d = hold_dl_q;
    cls_s     = cur_q;
    if (cfg_i.mode == slsm_pkg::MODE_INJ_NOLMP) begin
      if (closed || cnt) begin
        hold_d = 1'b1;
        arm_d  = 1'b0;
        cls_s  = closed ? slsm_pkg::ST_RUNNING : slsm_pkg::ST_READY;
      end else if (!hold_q) begin
        cls_s = slsm_pkg::ST_READY;
      end else if (!arm_q) begin
        arm_d     = 1'b1;
        hold_dl_d = hold_target;
        cls_s     = slsm_pkg::ST_RUNNING;
      end else if (hold_pass) begin
        hold_d = 1'b0;
        cls_s  = slsm_pkg::ST_READY;
      end else begin
        cls_s = slsm_pkg::ST_RUNNING;
      end
    end else if (red) begin
      arm_d = 1'b0;
      if (cfg_i.mode != slsm_pkg::MODE_MACHINING) begin
        hold_d = 1'b0;
      end
      cls_s = slsm_pkg::ST_ALERT;
    end else if (green) begin
      arm_d = 1'b0;
      cls_s = slsm_pkg::ST_RUNNING;
      if (cfg_i.mode != slsm_pkg::MODE_MACHINING) begin
        hold_d = 1'b1;
        if (cfg_i.mode == slsm_pkg::MODE_INJECTION) begin
          if (!closed && cnt) begin
            cls_s = slsm_pkg::ST_READY;
          end
        end else if (cnt) begin
          cls_s = slsm_pkg::ST_READY;
        end
      end
    end else if (yellow) begin
      arm_d = 1'b0;
      if (cfg_i.mode != slsm_pkg::MODE_MACHINING) begin
        hold_d = 1'b0;
      end
      cls_s = slsm_pkg::ST_READY;
    end else if (cfg_i.mode != slsm_pkg::MODE_MACHINING) begin
      if (hold_q) begin
        if (!arm_q) begin
          arm_d     = 1'b1;
          hold_dl_d = hold_target;
        end else if (hold_pass) begin
          cls_s  = slsm_pkg::ST_READY;
          hold_d = 1'b0;
        end
      end else begin
        cls_s = slsm_pkg::ST_READY;
      end
    end else if (cur_q == slsm_pkg::ST_RUNNING) begin
      cls_s = slsm_pkg::ST_RUNNING;
      if (!arm_q) begin
        arm_d     = 1'b1;
        hold_dl_d = hold_target;
      end else if (hold_pass) begin
        cls_s = slsm_pkg::ST_READY;
      end
    end else begin
      cls_s = slsm_pkg::ST_READY;
    end
  end

  assign report = (cls_s != cur_q) || rep_pass || limit_hit;

  // control and segment registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q       <= slsm_pkg::ST_NONE;
      hold_q      <= 1'b0;
      arm_q       <= 1'b0;
      hold_dl_q   <= '0;
      rep_dl_q    <= '0;
      piece_q     <= '0;
      start_q     <= '0;
      known_q     <= 1'b0;
      tick_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (take) begin
        tick_q    <= tick_q + 1'b1;
        arm_q     <= arm_d;
        hold_dl_q <= hold_dl_d;
        if (report) begin
          out_valid_q <= known_q;
          known_q     <= 1'b1;
          cur_q       <= cls_s;
          start_q     <= tick_q;
          hold_q      <= 1'b0;
          piece_q     <= '0;
          rep_dl_q    <= tick_q + TIME_BITS'(cfg_i.interval);
        end else begin
          hold_q  <= hold_d;
          piece_q <= piece_nx;
        end
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (take && report) begin
      segment_state_o    <= cur_q;
      segment_begin_o    <= 32'(start_q);
      segment_end_o      <= 32'(tick_q);
      segment_duration_o <= 32'(dur);
      run_hold_flag_o    <= (cfg_i.mode == slsm_pkg::MODE_MACHINING) ? 1'b0 : hold_d;
      segment_pieces_o   <= piece_nx;
      new_state_o        <= cls_s;
    end
  end

  assign out_valid_o = out_valid_q;

  // a reported segment always has a real state on both sides
  a_seg_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (segment_state_o != slsm_pkg::ST_NONE &&
                     new_state_o != slsm_pkg::ST_NONE))
    else $error("report with state none");

  // once reporting, the current state is never none
  a_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    known_q |-> cur_q != slsm_pkg::ST_NONE)
    else $error("segment known but state none");

  // tick advances exactly once per processed sample
  a_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> tick_q == $past(tick_q) + 1'b1)
    else $error("tick counter out of step");

endmodule

`default_nettype wire

// File: bench/stack_light_machine_state_monitor_test.sv
module stack_light_machine_state_monitor_test;
  timeunit 1ns;
  timeprecision 1ps;

  import slsm_pkg::*;

  localparam logic [7:0] DB_FALL = 8'h80;
  localparam logic [7:0] DB_RISE = 8'h7F;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 6;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_OFF_CYCLES = 60;

  // one segment report as it leaves the block
  typedef struct packed {
    state_e      seg_state;
    logic [31:0] seg_begin;
    logic [31:0] seg_end;
    logic [31:0] seg_dur;
    logic        hold;
    logic [15:0] pieces;
    state_e      next_state;
  } report_t;

  typedef enum logic [1:0] {
    CHK_MODEL = 2'd0,
    CHK_NONE  = 2'd1,
    CHK_TYPED = 2'd2
  } check_e;

  // pins bit order: piece count, mold close, yellow, green, red, common
  typedef struct packed {
    logic [5:0] pins;
    logic [7:0] reps;
    check_e     chk;
    report_t    known_rpt;
  } stim_row_t;

  typedef struct packed {
    mode_e       mode;
    logic [15:0] hold;
    logic [23:0] interval;
    logic [15:0] limit;
    logic [15:0] items;
  } phase_t;

  localparam report_t NO_RPT = '0;

  // directed rows, run with the reset configuration (machining, every tick reported)
  localparam stim_row_t DIRECTED [14] = '{
    '{6'b000000, 8'd1, CHK_NONE, NO_RPT},
    '{6'b000000, 8'd1, CHK_TYPED, '{ST_READY, 32'd0, 32'd1, 32'd1, 1'b0, 16'd0, ST_READY}},
    '{6'b111111, 8'd1, CHK_TYPED, '{ST_READY, 32'd1, 32'd2, 32'd1, 1'b0, 16'd0, ST_READY}},
    '{6'b111111, 8'd8, CHK_MODEL, NO_RPT},
    '{6'b111100, 8'd8, CHK_MODEL, NO_RPT},
    '{6'b110000, 8'd8, CHK_MODEL, NO_RPT},
    '{6'b111010, 8'd8, CHK_MODEL, NO_RPT},
    '{6'b011000, 8'd8, CHK_MODEL, NO_RPT},
    '{6'b111000, 8'd1, CHK_MODEL, NO_RPT},
    '{6'b011000, 8'd3, CHK_MODEL, NO_RPT},
    '{6'b111000, 8'd8, CHK_MODEL, NO_RPT},
    '{6'b011000, 8'd8, CHK_MODEL, NO_RPT},
    '{6'b000001, 8'd8, CHK_MODEL, NO_RPT},
    '{6'b001111, 8'd8, CHK_MODEL, NO_RPT}
  };

  // configuration settings walked by the random part, the last one without idling
  localparam phase_t PHASES [8] = '{
    '{MODE_MACHINING, 16'd5,     24'd200,      16'd3,     16'd120},
    '{MODE_INJECTION, 16'd0,     24'd0,        16'd0,     16'd100},
    '{MODE_PRESS,     16'd65535, 24'd16777215, 16'd65535, 16'd130},
    '{MODE_INJ_NOLMP, 16'd20,    24'd50,       16'd0,     16'd130},
    '{MODE_INJECTION, 16'd30,    24'd100,      16'd2,     16'd130},
    '{MODE_INJ_NOLMP, 16'd0,     24'd300,      16'd1,     16'd120},
    '{MODE_PRESS,     16'd10,    24'd1000,     16'd0,     16'd120},
    '{MODE_MACHINING, 16'd65535, 24'd16777215, 16'd65535, 16'd110}
  };

  logic                  clk_i;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic                  pin_common_i = 1'b0;
  logic                  pin_red_i = 1'b0;
  logic                  pin_green_i = 1'b0;
  logic                  pin_yellow_i = 1'b0;
  logic                  pin_mold_close_i = 1'b0;
  logic                  pin_piece_count_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [1:0]            segment_state_o;
  logic [31:0]           segment_begin_o;
  logic [31:0]           segment_end_o;
  logic [31:0]           segment_duration_o;
  logic                  run_hold_flag_o;
  logic [15:0]           segment_pieces_o;
  logic [1:0]            new_state_o;

  stack_light_machine_state_monitor dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .pin_common_i       (pin_common_i),
    .pin_red_i          (pin_red_i),
    .pin_green_i        (pin_green_i),
    .pin_yellow_i       (pin_yellow_i),
    .pin_mold_close_i   (pin_mold_close_i),
    .pin_piece_count_i  (pin_piece_count_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .segment_state_o    (segment_state_o),
    .segment_begin_o    (segment_begin_o),
    .segment_end_o      (segment_end_o),
    .segment_duration_o (segment_duration_o),
    .run_hold_flag_o    (run_hold_flag_o),
    .segment_pieces_o   (segment_pieces_o),
    .new_state_o        (new_state_o)
  );

  // predicted configuration
  mode_e       cfg_mode = MODE_MACHINING;
  logic [15:0] cfg_hold = '0;
  logic [23:0] cfg_interval = '0;
  logic [15:0] cfg_limit = '0;

  // predicted monitor state
  logic [7:0]  pin_hist [NUM_PINS];
  logic [5:0]  pin_level = '0;
  bit          awaiting_first = 1'b1;
  state_e      cur_state = ST_NONE;
  bit          hold_flag = 1'b0;
  bit          hold_armed = 1'b0;
  logic [31:0] hold_deadline = '0;
  logic [31:0] report_deadline = '0;
  logic [15:0] piece_count = '0;
  logic [31:0] seg_start = '0;
  bit          seg_known = 1'b0;
  logic [31:0] tick_now = '0;

  report_t     pending_reports [$];
  int          failures = 0;
  int          reports_taken = 0;
  int          next_hold_off = 80;
  int          hold_off_left = 0;
  int          stall_left = 0;
  int          quiet_cycles = 0;
  bit          quiet_tail = 1'b0;
  logic [5:0]  pin_base = '0;
  int          run_left = 0;
  report_t     want;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // wrapping deadline test: strictly later by less than half the range
  function automatic bit deadline_passed(input logic [31:0] now, input logic [31:0] dl);
    logic [31:0] d;
    d = now - dl;
    return (d != 0) && !d[31];
  endfunction

  // machine state from the debounced levels, updating hold state
  function automatic state_e classify_levels(input logic [31:0] now);
    bit red, green, yellow, closed, cnt;
    state_e s;
    red    = pin_level[PIN_RED] != pin_level[PIN_COM];
    green  = pin_level[PIN_GREEN] != pin_level[PIN_COM];
    yellow = pin_level[PIN_YEL] != pin_level[PIN_COM];
    closed = !pin_level[PIN_CLOSE];
    cnt    = !pin_level[PIN_COUNT];
    if (cfg_mode == MODE_INJ_NOLMP) begin
      if (closed || cnt) begin
        hold_flag = 1'b1;
        hold_armed = 1'b0;
        return closed ? ST_RUNNING : ST_READY;
      end
      if (!hold_flag) return ST_READY;
      // timer armed on the first idle tick instead of testing a stale deadline
      if (!hold_armed) begin
        hold_armed = 1'b1;
        hold_deadline = now + 32'(cfg_hold);
        return ST_RUNNING;
      end
      if (deadline_passed(now, hold_deadline)) begin
        hold_flag = 1'b0;
        return ST_READY;
      end
      return ST_RUNNING;
    end
    if (red) begin
      hold_armed = 1'b0;
      if (cfg_mode != MODE_MACHINING) hold_flag = 1'b0;
      return ST_ALERT;
    end
    if (green) begin
      hold_armed = 1'b0;
      if (cfg_mode == MODE_MACHINING) return ST_RUNNING;
      hold_flag = 1'b1;
      s = ST_RUNNING;
      if (cfg_mode == MODE_INJECTION) begin
        if (!closed && cnt) s = ST_READY;
      end else if (cnt) begin
        s = ST_READY;
      end
      return s;
    end
    if (yellow) begin
      hold_armed = 1'b0;
      if (cfg_mode != MODE_MACHINING) hold_flag = 1'b0;
      return ST_READY;
    end
    // lamps idle
    if (cfg_mode != MODE_MACHINING) begin
      s = cur_state;
      if (hold_flag) begin
        if (!hold_armed) begin
          hold_armed = 1'b1;
          hold_deadline = now + 32'(cfg_hold);
        end else if (deadline_passed(now, hold_deadline)) begin
          s = ST_READY;
          hold_flag = 1'b0;
        end
      end else begin
        s = ST_READY;
      end
      return s;
    end
    if (cur_state == ST_RUNNING) begin
      if (!hold_armed) begin
        hold_armed = 1'b1;
        hold_deadline = now + 32'(cfg_hold);
      end else if (deadline_passed(now, hold_deadline)) begin
        return ST_READY;
      end
      return ST_RUNNING;
    end
    return ST_READY;
  endfunction

  // one sample tick: debounce, classify, and the segment report it causes
  function automatic bit advance_tick(input logic [5:0] pins, output report_t rep);
    logic [31:0] now;
    state_e s;
    bit fired;
    now = tick_now;
    rep = '0;
    fired = 1'b0;
    for (int p = 0; p < NUM_PINS; p++) begin
      if (awaiting_first) begin
        pin_hist[p] = pins[p] ? 8'hFF : 8'h00;
        pin_level[p] = pins[p];
      end else begin
        pin_hist[p] = {pin_hist[p][6:0], pins[p]};
        if (pin_hist[p] == DB_FALL) begin
          pin_level[p] = 1'b0;
          if ((p == PIN_CLOSE && cfg_mode == MODE_INJECTION) ||
              (p == PIN_COUNT && cfg_mode != MODE_INJECTION)) begin
            if (piece_count != PIECE_MAX) piece_count++;
          end
        end else if (pin_hist[p] == DB_RISE) begin
          pin_level[p] = 1'b1;
        end
      end
    end
    awaiting_first = 1'b0;
    s = classify_levels(now);
    if (cur_state != s || deadline_passed(now, report_deadline) ||
        (cfg_limit != 0 && piece_count >= cfg_limit)) begin
      // the very first segment start is not reported
      if (seg_known) begin
        rep.seg_state = cur_state;
        rep.seg_begin = seg_start;
        rep.seg_end = now;
        rep.seg_dur = now - seg_start;
        rep.hold = (cfg_mode == MODE_MACHINING) ? 1'b0 : hold_flag;
        rep.pieces = piece_count;
        rep.next_state = s;
        fired = 1'b1;
      end
      seg_known = 1'b1;
      cur_state = s;
      seg_start = now;
      hold_flag = 1'b0;
      piece_count = '0;
      report_deadline = now + 32'(cfg_interval);
    end
    tick_now = now + 1;
    return fired;
  endfunction

  // random pin runs: mostly long enough to pass the debouncer, some short, some glitches
  function automatic logic [5:0] next_pins();
    logic [5:0] pins;
    if (run_left == 0) begin
      run_left = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 6) : $urandom_range(7, 24);
      pin_base[$urandom_range(0, 5)] ^= 1'b1;
      if ($urandom_range(0, 2) == 0) pin_base[$urandom_range(0, 5)] ^= 1'b1;
    end
    run_left--;
    pins = pin_base;
    if ($urandom_range(0, 24) == 0) pins[$urandom_range(0, 5)] ^= 1'b1;
    return pins;
  endfunction

  task automatic write_register(input cfg_idx_e idx, input logic [23:0] value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    case (idx)
      CFG_MODE:     cfg_mode = mode_e'(value[1:0]);
      CFG_RUN_HOLD: cfg_hold = value[15:0];
      CFG_INTERVAL: cfg_interval = value;
      CFG_LIMIT:    cfg_limit = value[15:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // offer one sample, wait for its transaction, then record what it should cause
  task automatic offer_sample(input logic [5:0] pins, input check_e chk, input report_t known);
    int gap;
    report_t rep;
    bit got;
    gap = (!quiet_tail && $urandom_range(0, 5) == 0) ? $urandom_range(1, 12) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pin_common_i <= pins[PIN_COM];
    pin_red_i <= pins[PIN_RED];
    pin_green_i <= pins[PIN_GREEN];
    pin_yellow_i <= pins[PIN_YEL];
    pin_mold_close_i <= pins[PIN_CLOSE];
    pin_piece_count_i <= pins[PIN_COUNT];
    do @(posedge clk_i); while (!in_ready_o);
    got = advance_tick(pins, rep);
    case (chk)
      CHK_MODEL: if (got) pending_reports.push_back(rep);
      CHK_TYPED: pending_reports.push_back(known);
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      failures++;
    end
  endtask

  // report checking and receiver stalls
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      reports_taken++;
      if (pending_reports.size() == 0) begin
        $error("unexpected segment report, new state %0d", new_state_o);
        failures++;
      end else begin
        want = pending_reports.pop_front();
        check_field("segment_state", 32'(want.seg_state), 32'(segment_state_o));
        check_field("segment_begin", want.seg_begin, segment_begin_o);
        check_field("segment_end", want.seg_end, segment_end_o);
        check_field("segment_duration", want.seg_dur, segment_duration_o);
        check_field("run_hold_flag", 32'(want.hold), 32'(run_hold_flag_o));
        check_field("segment_pieces", 32'(want.pieces), 32'(segment_pieces_o));
        check_field("new_state", 32'(want.next_state), 32'(new_state_o));
      end
    end
    if (hold_off_left != 0) begin
      hold_off_left--;
      out_ready_i <= 1'b0;
    end else if (!quiet_tail && reports_taken >= next_hold_off) begin
      // long hold-off so the queue fills and the input stalls
      hold_off_left = HOLD_OFF_CYCLES - 1;
      next_hold_off += 300;
      out_ready_i <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 11);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part under the reset configuration
    foreach (DIRECTED[r]) begin
      for (int k = 0; k < DIRECTED[r].reps; k++) begin
        offer_sample(DIRECTED[r].pins, DIRECTED[r].chk, DIRECTED[r].known_rpt);
      end
    end

    // random part, one configuration setting per phase
    foreach (PHASES[ph]) begin
      in_valid_i <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clk_i);
      repeat (SETTLE_CYCLES) @(posedge clk_i);
      quiet_tail = (ph == $size(PHASES) - 1);
      write_register(CFG_MODE, 24'(PHASES[ph].mode));
      write_register(CFG_RUN_HOLD, 24'(PHASES[ph].hold));
      write_register(CFG_INTERVAL, PHASES[ph].interval);
      write_register(CFG_LIMIT, 24'(PHASES[ph].limit));
      cfg_we_i <= 1'b0;
      for (int k = 0; k < PHASES[ph].items; k++) begin
        offer_sample(next_pins(), CHK_MODEL, NO_RPT);
      end
    end

    in_valid_i <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/slsm_pkg.sv
rtl/core/slsm_front.sv
rtl/core/slsm_queue.sv
rtl/core/slsm_back.sv
rtl/core/stack_light_machine_state_monitor.sv
bench/stack_light_machine_state_monitor_test.sv
